>>> rtl/core/ffpsq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ffpsq_pkg;

   localparam int unsigned WordWidth   = 32;
   localparam int unsigned StatusWidth = 2;
   localparam int unsigned ExpWidth    = 8;
   localparam int unsigned StepWidth   = 5;

   localparam logic [StepWidth-1:0] RootSteps = 5'd25;

   localparam logic [WordWidth-1:0] TopBit      = 32'h8000_0000;
   localparam logic [WordWidth-1:0] MantMask    = 32'hFFFF_FF00;
   localparam logic [WordWidth-1:0] RoundAdd    = 32'h0000_0100;
   localparam logic [ExpWidth-1:0]  ExpBiasEven = 8'h20;
   localparam logic [ExpWidth-1:0]  ExpBiasOdd  = 8'h21;

   typedef logic [WordWidth-1:0]   word_type;
   typedef logic [StatusWidth-1:0] status_type;

   localparam status_type StatusNormal   = 2'd0;
   localparam status_type StatusZero     = 2'd1;
   localparam status_type StatusOverflow = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ROOT,
      ST_PACK
   } state_type;

endpackage

`default_nettype wire

>>> rtl/core/ffpsq_req_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface ffpsq_req_if
   import ffpsq_pkg::*;
   ;
   logic     valid;
   logic     ready;
   word_type operand;

   modport source (output valid, output operand, input ready);
   modport sink   (input valid, input operand, output ready);
endinterface

interface ffpsq_rsp_if
   import ffpsq_pkg::*;
   ;
   logic       valid;
   logic       ready;
   word_type   root;
   status_type status;

   modport source (output valid, output root, output status, input ready);
   modport sink   (input valid, input root, input status, output ready);
endinterface

`default_nettype wire

>>> rtl/core/ffp_square_root_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Channel   Modport  Payload                          Handshake
// req_ch    sink     operand[31:0] (FFP word)         valid & ready
// rsp_ch    source   root[31:0], status[1:0]          valid & ready
//
// An ordinary operand stays in ROOT for one step per root bit (1 to 25 steps, fewer on an
// exact match) and then goes to PACK, and the next item is taken back in IDLE. Zero,
// negative and zero-mantissa operands go straight from IDLE to PACK. Reset is synchronous
// and active high and returns the sequencer to idle with an empty result register. PACK
// waits while an unread result still holds the result register, so a stall delays the
// next item.

module ffp_square_root_core
   import ffpsq_pkg::*;
(
   input  wire          clock,
   input  wire          reset,
   ffpsq_req_if.sink    req_ch,
   ffpsq_rsp_if.source  rsp_ch
);

   // Sequencer state.
   state_type state_ff, state_in;

   // Operand and root-loop registers. All of the loop terms move by shifts, so each
   // step needs only one add of three words and one compare against the target.
   word_type             w_ff;       // accepted operand
   word_type             target_ff;  // mantissa fraction, halved for odd exponents
   word_type             sq_ff;      // square of the root so far
   word_type             r_ff;       // root so far
   word_type             rsh_ff;     // root shifted right by the step count
   word_type             q_ff;       // current root bit shifted right by the step count
   word_type             d_ff;       // current root bit
   logic [StepWidth-1:0] z_ff;       // step count

   // Result register.
   logic       rsp_valid_ff, rsp_valid_in;
   word_type   rsp_root_ff;
   status_type rsp_status_ff;

   // Control decoded from the state.
   logic load;
   logic step;
   logic pack;
   logic out_free;

   // Datapath.
   word_type             target_new;
   word_type             trial;
   logic                 keep;
   logic [StepWidth-1:0] z_next;
   logic                 loop_done;
   logic                 special;
   logic [ExpWidth-1:0]  exp_new;
   word_type             rounded;
   word_type             pack_root;
   status_type           pack_status;

   assign out_free = !rsp_valid_ff || rsp_ch.ready;

   // An operand that is zero, negative or has a zero mantissa needs no root loop.
   assign target_new = req_ch.operand[0] ? ((req_ch.operand & MantMask) >> 1)
                                         : (req_ch.operand & MantMask);
   assign special    = (req_ch.operand == '0) || req_ch.operand[7] || (target_new == '0);

   // One root bit per cycle: the trial square is formed from the running square,
   // the shifted root and the shifted square of the new bit.
   assign trial     = sq_ff + rsh_ff + (q_ff >> 1);
   assign keep      = (trial <= target_ff);
   assign z_next    = z_ff + 1'b1;
   assign loop_done = (z_next == RootSteps) || (keep && (trial == target_ff));

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_ch.valid) begin
               state_in = special ? ST_PACK : ST_ROOT;
            end
         end
         ST_ROOT: begin
            if (loop_done) begin
               state_in = ST_PACK;
            end
         end
         ST_PACK: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output logic of the sequencer.
   always_comb begin
      req_ch.ready = 1'b0;
      step         = 1'b0;
      pack         = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ch.ready = 1'b1;
         end
         ST_ROOT: begin
            step = 1'b1;
         end
         ST_PACK: begin
            pack = out_free;
         end
         default: begin
            req_ch.ready = 1'b0;
         end
      endcase
   end

   assign load = req_ch.valid && req_ch.ready;

   // Rounding and packing. The exponent is halved and rebiased; a carry out of the
   // rounding add is dropped and the result is not renormalized.
   assign exp_new = {2'b00, w_ff[6:1]} + (w_ff[0] ? ExpBiasOdd : ExpBiasEven);
   assign rounded = r_ff[7] ? (r_ff + RoundAdd) : r_ff;

   always_comb begin
      if (w_ff == '0) begin
         pack_root   = '0;
         pack_status = StatusZero;
      end else if (w_ff[7]) begin
         pack_root   = w_ff;
         pack_status = StatusOverflow;
      end else begin
         pack_root   = (rounded & MantMask) | {{(WordWidth-ExpWidth){1'b0}}, exp_new};
         pack_status = StatusNormal;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (pack) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Root-loop shift registers.
   always_ff @(posedge clock) begin
      if (load) begin
         w_ff      <= req_ch.operand;
         target_ff <= target_new;
         sq_ff     <= '0;
         r_ff      <= '0;
         rsh_ff    <= '0;
         q_ff      <= TopBit;
         d_ff      <= TopBit;
         z_ff      <= '0;
      end else if (step) begin
         if (keep) begin
            sq_ff  <= trial;
            r_ff   <= r_ff | d_ff;
            rsh_ff <= (rsh_ff | q_ff) >> 1;
         end else begin
            rsh_ff <= rsh_ff >> 1;
         end
         q_ff <= q_ff >> 2;
         d_ff <= d_ff >> 1;
         z_ff <= z_next;
      end
   end

   // Result payload.
   always_ff @(posedge clock) begin
      if (pack) begin
         rsp_root_ff   <= pack_root;
         rsp_status_ff <= pack_status;
      end
   end

   assign rsp_ch.valid  = rsp_valid_ff;
   assign rsp_ch.root   = rsp_root_ff;
   assign rsp_ch.status = rsp_status_ff;

endmodule

`default_nettype wire
